>>> sv/sorted_layer_table_macros.svh
// Assertion macros for the sorted layer table
`ifndef SORTED_LAYER_TABLE_MACROS_SVH
`define SORTED_LAYER_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SLT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SLT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/slt_pkg.sv
// Types and constants shared by the sorted layer table modules
package slt_pkg;

	typedef enum logic [1:0] {
		OP_READ   = 2'd0,
		OP_INSERT = 2'd1,
		OP_WRITE  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] height;
		logic [7:0] idx;
		logic [7:0] value;
		logic       idx_ok;
	} cmd_t;

	typedef struct packed {
		logic [7:0] position;
		logic [7:0] block_code;
		logic       found;
		logic       inserted;
		logic       full_res;
	} res_t;

	typedef struct packed {
		logic       busy;
		logic [8:0] layer_count;
	} stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CMP,
		ST_CHK,
		ST_CHKCMP,
		ST_ADDR,
		ST_BRD,
		ST_BRDW,
		ST_BWR,
		ST_SHRD,
		ST_SHWR,
		ST_PUT,
		ST_FILL
	} state_t;

	localparam logic [0:0] REG_AIR_CODE = 1'b0;

endpackage

>>> sv/slt_if.sv
// Request and response channel interfaces
interface slt_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] layer_height;
	logic [7:0] block_index;
	logic [7:0] block_value;

	modport source (output valid, func, layer_height, block_index, block_value, input ready);
	modport sink (input valid, func, layer_height, block_index, block_value, output ready);
endinterface

interface slt_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] position;
	logic [7:0] block_code;
	logic       found;
	logic       inserted;
	logic       full_res;

	modport source (output valid, position, block_code, found, inserted, full_res, input ready);
	modport sink (input valid, position, block_code, found, inserted, full_res, output ready);
endinterface

>>> sv/sorted_layer_table.sv
// Top level of the sorted layer table: front queue, engine and register port
// A table of layers kept in height order, each holding a row of block codes.
// Requests pass through a two-entry queue to a single engine that works on one
// request at a time. The engine finds the layer by binary search over the
// position-map memory and checks the entry it ends on; a block read or write then
// accesses the row of that layer in block memory. An insert additionally moves
// every later map entry up by one, writes the new map entry, then fills the new
// row with the air code at one block per cycle. The result sits in an output
// register; the queue keeps taking requests while a result waits, until full.
`include "sorted_layer_table_macros.svh"
module sorted_layer_table #(
	parameter int MAX_LAYERS       = 256,
	parameter int BLOCKS_PER_LAYER = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	slt_req_if.sink     req,
	slt_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import slt_pkg::*;

	logic       cmd_valid;
	cmd_t       cmd;
	logic       cmd_pop;
	stat_t      stat;
	logic [7:0] air_q;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_AIR_CODE) ? {24'd0, air_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			air_q <= 8'd0;
		end else if (psel && penable && pwrite && pready && paddr == REG_AIR_CODE) begin
			air_q <= pwdata[7:0];
		end
	end

	slt_front #(
		.BLOCKS_PER_LAYER(BLOCKS_PER_LAYER)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop)
	);

	slt_back #(
		.MAX_LAYERS      (MAX_LAYERS),
		.BLOCKS_PER_LAYER(BLOCKS_PER_LAYER)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.air_code (air_q),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.rsp      (rsp),
		.stat     (stat)
	);

	`SLT_ASSERT_IMP(a_pop_nonempty, cmd_pop, cmd_valid, "engine popped an empty queue")
	`SLT_ASSERT_IMP(a_count_max, 1'b1, stat.layer_count <= 9'(MAX_LAYERS), "layer count over limit")
	`SLT_ASSERT_NXT(a_pop_busy, cmd_pop, stat.busy, "engine idle after taking a request")

endmodule

>>> sv/slt_front.sv
// Front end: takes requests, decodes them and queues them for the engine
module slt_front #(
	parameter int BLOCKS_PER_LAYER = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	slt_req_if.sink       req,
	output logic          cmd_valid,
	output slt_pkg::cmd_t cmd,
	input  logic          cmd_pop
);
	import slt_pkg::*;

	cmd_t       q_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] n_q;
	cmd_t       dec;
	logic       push;

	always_comb begin
		dec        = '0;
		dec.op     = op_t'(req.func);
		dec.height = req.layer_height;
		dec.idx    = req.block_index;
		dec.value  = req.block_value;
		dec.idx_ok = {1'b0, req.block_index} < 9'(BLOCKS_PER_LAYER);
	end

	assign req.ready = (n_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign cmd_valid = (n_q != 2'd0);
	assign cmd       = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			n_q  <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (cmd_pop) begin
				rp_q <= ~rp_q;
			end
			n_q <= n_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end

endmodule

>>> sv/slt_back.sv
// Engine: binary search, position map shift, row fill and block access
module slt_back #(
	parameter int MAX_LAYERS       = 256,
	parameter int BLOCKS_PER_LAYER = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     air_code,
	input  logic           cmd_valid,
	input  slt_pkg::cmd_t  cmd,
	output logic           cmd_pop,
	slt_rsp_if.source      rsp,
	output slt_pkg::stat_t stat
);
	import slt_pkg::*;

	localparam int LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
	localparam int CW = $clog2(MAX_LAYERS + 1);
	localparam int BW = $clog2(BLOCKS_PER_LAYER);
	localparam int AW = $clog2(MAX_LAYERS * BLOCKS_PER_LAYER);

	// position map: height and row of each sorted position
	logic [7:0]    hmem_h [MAX_LAYERS];
	logic [LW-1:0] hmem_r [MAX_LAYERS];
	logic [7:0]    blk_mem [MAX_LAYERS * BLOCKS_PER_LAYER];

	state_t        st_q, st_d;
	cmd_t          cmd_q;
	logic [CW-1:0] cnt_q, lo_q, hi_q, mid_q, i_q;
	logic          inb_q, fnd_q;
	logic [LW-1:0] row_q;
	logic [AW-1:0] addr_q;
	logic [BW-1:0] f_q;
	res_t          res_q, res_d;
	logic          res_vq, fin;

	logic [CW:0]   sum;
	logic [CW-1:0] mid;
	logic [LW-1:0] h_ra, h_wa;
	logic          h_we;
	logic [7:0]    h_wd;
	logic [LW-1:0] r_wd;
	logic [7:0]    h_rd_q;
	logic [LW-1:0] r_rd_q;
	logic [AW-1:0] b_addr;
	logic          b_we;
	logic [7:0]    b_wd;
	logic [7:0]    b_rd_q;
	logic [LW-1:0] rowsel;

	assign sum    = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid    = sum[CW:1];
	assign rowsel = fnd_q ? row_q : cnt_q[LW-1:0];

	always_comb begin
		st_d    = st_q;
		cmd_pop = 1'b0;
		fin     = 1'b0;
		res_d   = '0;
		h_ra    = lo_q[LW-1:0];
		h_wa    = lo_q[LW-1:0];
		h_we    = 1'b0;
		h_wd    = h_rd_q;
		r_wd    = r_rd_q;
		b_addr  = addr_q;
		b_we    = 1'b0;
		b_wd    = cmd_q.value;
		case (st_q)
			ST_IDLE: begin
				if (cmd_valid && !res_vq) begin
					cmd_pop = 1'b1;
					st_d    = ST_PROBE;
				end
			end
			ST_PROBE: begin
				h_ra = mid[LW-1:0];
				st_d = (lo_q < hi_q) ? ST_CMP : ST_CHK;
			end
			ST_CMP: st_d = ST_PROBE;
			ST_CHK: begin
				h_ra = lo_q[LW-1:0];
				st_d = ST_CHKCMP;
			end
			ST_CHKCMP: st_d = ST_ADDR;
			ST_ADDR: begin
				res_d.found    = fnd_q && (cmd_q.op != OP_NONE);
				res_d.position = fnd_q ? 8'(lo_q) : 8'd0;
				res_d.block_code = air_code;
				case (cmd_q.op)
					OP_READ: begin
						if (fnd_q && cmd_q.idx_ok) st_d = ST_BRD;
						else fin = 1'b1;
					end
					OP_WRITE: begin
						if (fnd_q && cmd_q.idx_ok) st_d = ST_BWR;
						else fin = 1'b1;
					end
					OP_INSERT: begin
						res_d.block_code = 8'd0;
						if (fnd_q) begin
							fin = 1'b1;
						end else if (cnt_q == CW'(MAX_LAYERS)) begin
							res_d.full_res = 1'b1;
							fin            = 1'b1;
						end else begin
							st_d = ST_SHRD;
						end
					end
					default: begin
						res_d = '0;
						fin   = 1'b1;
					end
				endcase
			end
			ST_BRD: st_d = ST_BRDW;
			ST_BRDW: begin
				res_d.found      = 1'b1;
				res_d.position   = 8'(lo_q);
				res_d.block_code = b_rd_q;
				fin              = 1'b1;
			end
			ST_BWR: begin
				b_we             = 1'b1;
				res_d.found      = 1'b1;
				res_d.position   = 8'(lo_q);
				res_d.block_code = cmd_q.value;
				fin              = 1'b1;
			end
			ST_SHRD: begin
				h_ra = LW'(i_q - CW'(1));
				st_d = (i_q > lo_q) ? ST_SHWR : ST_PUT;
			end
			ST_SHWR: begin
				h_wa = i_q[LW-1:0];
				h_we = 1'b1;
				st_d = ST_SHRD;
			end
			ST_PUT: begin
				h_we = 1'b1;
				h_wd = cmd_q.height;
				r_wd = cnt_q[LW-1:0];
				st_d = ST_FILL;
			end
			ST_FILL: begin
				b_addr = addr_q + AW'(f_q);
				b_we   = 1'b1;
				b_wd   = air_code;
				if (f_q == BW'(BLOCKS_PER_LAYER - 1)) begin
					res_d.position = 8'(lo_q);
					res_d.inserted = 1'b1;
					fin            = 1'b1;
				end
			end
			default: st_d = ST_IDLE;
		endcase
		if (fin) begin
			st_d = ST_IDLE;
		end
	end

	always_ff @(posedge clk) begin
		if (h_we) begin
			hmem_h[h_wa] <= h_wd;
			hmem_r[h_wa] <= r_wd;
		end
		h_rd_q <= hmem_h[h_ra];
		r_rd_q <= hmem_r[h_ra];
	end

	always_ff @(posedge clk) begin
		if (b_we) begin
			blk_mem[b_addr] <= b_wd;
		end
		b_rd_q <= blk_mem[b_addr];
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				cmd_q <= cmd;
				lo_q  <= '0;
				hi_q  <= cnt_q;
			end
			ST_PROBE: mid_q <= mid;
			ST_CMP: begin
				if (h_rd_q < cmd_q.height) lo_q <= mid_q + CW'(1);
				else hi_q <= mid_q;
			end
			ST_CHK: inb_q <= (lo_q < cnt_q);
			ST_CHKCMP: begin
				fnd_q <= inb_q && (h_rd_q == cmd_q.height);
				row_q <= r_rd_q;
			end
			ST_ADDR: begin
				addr_q <= AW'(rowsel) * AW'(BLOCKS_PER_LAYER)
					+ ((cmd_q.op == OP_INSERT) ? AW'(0) : AW'(cmd_q.idx));
				i_q    <= cnt_q;
				f_q    <= '0;
			end
			ST_SHWR: i_q <= i_q - CW'(1);
			ST_FILL: f_q <= f_q + BW'(1);
			default: ;
		endcase
		if (fin) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			cnt_q  <= '0;
			res_vq <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_FILL && fin) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (fin) res_vq <= 1'b1;
			else if (rsp.ready) res_vq <= 1'b0;
		end
	end

	assign rsp.valid      = res_vq;
	assign rsp.position   = res_q.position;
	assign rsp.block_code = res_q.block_code;
	assign rsp.found      = res_q.found;
	assign rsp.inserted   = res_q.inserted;
	assign rsp.full_res   = res_q.full_res;

	assign stat.busy        = (st_q != ST_IDLE);
	assign stat.layer_count = 9'(cnt_q);

endmodule
